/* hdl/tsa_pkg.sv */
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared constants, types and elaboration-time functions for the terrain
// slope and aspect core.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int ELEV_BITS_DEF       = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'd1;

  localparam int CORDIC_ITERS = 40;
  localparam int DIV_STEPS    = 40;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_W     = 62;
  localparam int VA_LAT       = CORDIC_ITERS + DIV_STEPS + 5;

  localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
  localparam logic [63:0] HALF_PI  = PI_Q61 >> 1;

  typedef enum logic [1:0] {
    VA_ZERO,
    VA_RIGHT,
    VA_CORDIC
  } va_mode_e;

  function automatic logic [6:0] bitlen(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // shift-subtract long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in radians, 61 fractional bits, truncated power series
  function automatic logic [63:0] step_angle(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q61 >> 2;
    end else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 61) begin
          e    = 61 - i * (2 * k + 1);
          term = udiv64(64'd1 << e, 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

/* hdl/tsa_in_if.sv */
// ----------------------------------------------------------------------------
// tsa_in_if
// Input channel: four neighbour elevations per item.
// ----------------------------------------------------------------------------
interface tsa_in_if #(
  parameter int ELEV_BITS = tsa_pkg::ELEV_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEV_BITS-1:0] elev_top;
  logic signed [ELEV_BITS-1:0] elev_bottom;
  logic signed [ELEV_BITS-1:0] elev_left;
  logic signed [ELEV_BITS-1:0] elev_right;

  modport source (output valid, elev_top, elev_bottom, elev_left, elev_right,
                  input ready);
  modport sink (input valid, elev_top, elev_bottom, elev_left, elev_right,
                output ready);
endinterface

/* hdl/tsa_out_if.sv */
// ----------------------------------------------------------------------------
// tsa_out_if
// Output channel: slope and aspect per item.
// ----------------------------------------------------------------------------
interface tsa_out_if #(
  parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ANGLE_FRAC_BITS+6:0]   slope_deg;
  logic [ANGLE_FRAC_BITS+8:0]   aspect_deg;

  modport source (output valid, slope_deg, aspect_deg, input ready);
  modport sink (input valid, slope_deg, aspect_deg, output ready);
endinterface

/* hdl/tsa_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tsa_sqrt_cell
// One digit step of the integer square root.
// ----------------------------------------------------------------------------
module tsa_sqrt_cell #(
  parameter int K = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] n_i,
  input  logic [63:0] res_i,
  output logic [63:0] n_o,
  output logic [63:0] res_o
);
  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

  logic [63:0] trial;
  logic [63:0] n_d, n_q, res_d, res_q;

  always_comb begin
    trial = res_i + BIT;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      res_q <= res_d;
    end
  end

  assign n_o   = n_q;
  assign res_o = res_q;
endmodule

/* hdl/tsa_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tsa_cordic_cell
// One vectoring rotation of the CORDIC chain.
// ----------------------------------------------------------------------------
module tsa_cordic_cell #(
  parameter int I  = 0,
  parameter int CW = tsa_pkg::CORDIC_W
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [63:0]   z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [63:0]   z_o
);
  localparam logic signed [63:0] ANG = signed'(tsa_pkg::step_angle(I));

  logic signed [CW-1:0] x_d, x_q, y_d, y_q;
  logic signed [63:0]   z_d, z_q;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> I);
      y_d = y_i - (x_i >>> I);
      z_d = z_i + ANG;
    end else begin
      x_d = x_i - (y_i >>> I);
      y_d = y_i + (x_i >>> I);
      z_d = z_i - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* hdl/tsa_div_cell.sv */
// ----------------------------------------------------------------------------
// tsa_div_cell
// One quotient bit of the radians to half-turn division by pi.
// ----------------------------------------------------------------------------
module tsa_div_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [63:0]                    r_i,
  input  logic [tsa_pkg::DIV_STEPS-1:0]  q_i,
  output logic [63:0]                    r_o,
  output logic [tsa_pkg::DIV_STEPS-1:0]  q_o
);
  logic [63:0]                   t;
  logic [63:0]                   r_d, r_q;
  logic [tsa_pkg::DIV_STEPS-1:0] q_d, q_q;

  always_comb begin
    t   = r_i << 1;
    q_d = q_i << 1;
    r_d = t;
    if (t >= tsa_pkg::PI_Q61) begin
      r_d    = t - tsa_pkg::PI_Q61;
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign r_o = r_q;
  assign q_o = q_q;
endmodule

/* hdl/tsa_vec_angle.sv */
// ----------------------------------------------------------------------------
// tsa_vec_angle
// First-quadrant angle of (x, y) in degrees: normalise, CORDIC chain,
// division chain and rounding.
// ----------------------------------------------------------------------------
module tsa_vec_angle #(
  parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [63:0]                x_i,
  input  logic [63:0]                y_i,
  output logic [ANGLE_FRAC_BITS+6:0] ang_o
);
  localparam int AGW = ANGLE_FRAC_BITS + 7;
  localparam int NI  = tsa_pkg::CORDIC_ITERS;
  localparam int ND  = tsa_pkg::DIV_STEPS;
  localparam int CW  = tsa_pkg::CORDIC_W;
  localparam int NM  = NI + ND + 3;
  localparam logic [AGW-1:0] RIGHT = AGW'(90) << ANGLE_FRAC_BITS;

  logic [63:0]        x1_q, y1_q;
  logic [6:0]         len1_q;
  tsa_pkg::va_mode_e  mode1_q;

  logic [63:0]        xs, ys;
  tsa_pkg::va_mode_e  mode2_d;
  logic signed [CW-1:0] x2_q, y2_q;
  tsa_pkg::va_mode_e  md_q [NM];

  logic signed [CW-1:0] xw [NI+1];
  logic signed [CW-1:0] yw [NI+1];
  logic signed [63:0]   zw [NI+1];

  logic [63:0]        r3_d, r3_q;
  logic [63:0]        rw [ND+1];
  logic [ND-1:0]      qw [ND+1];

  logic [ND+7:0]      p4_q;
  logic [63:0]        t5;
  logic [AGW-1:0]     ang_d, ang_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x_i;
      y1_q   <= y_i;
      len1_q <= tsa_pkg::bitlen((x_i > y_i) ? x_i : y_i);
      if (y_i == 64'd0) mode1_q <= tsa_pkg::VA_ZERO;
      else if (x_i == 64'd0) mode1_q <= tsa_pkg::VA_RIGHT;
      else mode1_q <= tsa_pkg::VA_CORDIC;
    end
  end

  always_comb begin
    if (len1_q > 7'd58) begin
      xs = x1_q >> (len1_q - 7'd58);
      ys = y1_q >> (len1_q - 7'd58);
    end else begin
      xs = x1_q << (7'd58 - len1_q);
      ys = y1_q << (7'd58 - len1_q);
    end
    mode2_d = mode1_q;
    if (mode1_q == tsa_pkg::VA_CORDIC) begin
      if (ys == 64'd0) mode2_d = tsa_pkg::VA_ZERO;
      else if (xs == 64'd0) mode2_d = tsa_pkg::VA_RIGHT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q     <= signed'(CW'(xs));
      y2_q     <= signed'(CW'(ys));
      md_q[0]  <= mode2_d;
      for (int j = 1; j < NM; j++) md_q[j] <= md_q[j-1];
    end
  end

  assign xw[0] = x2_q;
  assign yw[0] = y2_q;
  assign zw[0] = '0;

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    tsa_cordic_cell #(.I(i), .CW(CW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (xw[i]),
      .y_i   (yw[i]),
      .z_i   (zw[i]),
      .x_o   (xw[i+1]),
      .y_o   (yw[i+1]),
      .z_o   (zw[i+1])
    );
  end

  always_comb begin
    if (zw[NI] < 0) r3_d = '0;
    else if (zw[NI] > signed'(tsa_pkg::HALF_PI)) r3_d = tsa_pkg::HALF_PI;
    else r3_d = unsigned'(zw[NI]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r3_q <= r3_d;
  end

  assign rw[0] = r3_q;
  assign qw[0] = '0;

  for (genvar j = 0; j < ND; j++) begin : g_div
    tsa_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .r_i   (rw[j]),
      .q_i   (qw[j]),
      .r_o   (rw[j+1]),
      .q_o   (qw[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p4_q <= (ND+8)'(qw[ND]) * (ND+8)'(180);
  end

  always_comb begin
    t5 = ((64'(p4_q) << ANGLE_FRAC_BITS) + (64'd1 << 39)) >> 40;
    if (t5 > 64'(RIGHT)) ang_d = RIGHT;
    else ang_d = AGW'(t5);
    case (md_q[NM-1])
      tsa_pkg::VA_ZERO:  ang_d = '0;
      tsa_pkg::VA_RIGHT: ang_d = RIGHT;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ang_q <= ang_d;
  end

  assign ang_o = ang_q;
endmodule

/* hdl/terrain_slope_aspect_core.sv */
// ----------------------------------------------------------------------------
// terrain_slope_aspect_core
// Slope and aspect of a raster cell from its four neighbour elevations.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per cell: the top, bottom, left and right
//   neighbour elevations. out_o gives one item back: slope_deg (0..90) and
//   aspect_deg (0..<360), both with ANGLE_FRAC_BITS fractional bits.
//   Cell spacing is set through the write port (index 0 cell width,
//   index 1 cell height); both reset to 1 and 0 is taken as 1. Write only
//   while no item is in flight.
//   Throughput: one item per cycle unless the receiver stalls. Items pass
//   to the output register through the 32-step square root chain, the
//   40-step CORDIC chain and the 40-step division by pi.
//   The whole chain advances when the output register is empty or taken;
//   if the receiver stalls with a result held, every stage holds and
//   in_i.ready falls in the same cycle.
//   Reset empties the chain (no valid items) and restores the spacings.
// ----------------------------------------------------------------------------
module terrain_slope_aspect_core #(
  parameter int ELEV_BITS       = tsa_pkg::ELEV_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsa_pkg::CFG_W-1:0]     cfg_data_i,
  tsa_in_if.sink                        in_i,
  tsa_out_if.source                     out_o
);
  localparam int DW   = ELEV_BITS + 1;
  localparam int AW   = ELEV_BITS + 16;
  localparam int CW2  = 33;
  localparam int NSQ  = tsa_pkg::SQRT_STEPS;
  localparam int VLAT = tsa_pkg::VA_LAT;
  localparam int TOT  = 5 + NSQ + 1 + VLAT + 1;
  localparam int AGW  = ANGLE_FRAC_BITS + 7;
  localparam int SW   = ANGLE_FRAC_BITS + 7;
  localparam int ASW  = ANGLE_FRAC_BITS + 9;
  localparam int BW   = ANGLE_FRAC_BITS + 10;
  localparam logic [BW-1:0] R1 = BW'(90) << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic [AW-1:0]  ax;
    logic [AW-1:0]  ay;
    logic [CW2-1:0] c;
    logic [6:0]     len;
    logic           dxn;
    logic           dyn;
  } side_t;

  typedef struct packed {
    logic flat;
    logic dxn;
    logic dyn;
  } flag_t;

  logic [tsa_pkg::CFG_W-1:0] cw_q, ch_q, cx, cy;
  logic                      en;
  logic [TOT-1:0]            v_q;

  logic signed [DW-1:0] dx, dy;
  logic [ELEV_BITS-1:0] adx, ady;
  logic [AW-1:0]        ax1_q, ay1_q;
  logic [CW2-1:0]       c1_q;
  logic                 dxn1_q, dyn1_q;

  side_t       sd2_q, sd3_q, sd4_q, sd5_q;
  side_t       sd_q [NSQ];
  logic [30:0] a3_q, b3_q;
  logic [61:0] aa4_q, bb4_q;
  logic [62:0] n5_q;
  logic [63:0] nw [NSQ+1];
  logic [63:0] rw [NSQ+1];

  side_t       s6;
  logic [63:0] h6, sx6_d, sy6_d;
  logic [63:0] sx6_q, sy6_q, px6_q, py6_q;
  flag_t       fl6_q;
  flag_t       fl_q [VLAT];

  logic [AGW-1:0] slope_ang, asp_base;
  logic [BW-1:0]  asp;
  logic [SW-1:0]  slope_q;
  logic [ASW-1:0] aspect_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= tsa_pkg::CFG_W'(1);
      ch_q <= tsa_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsa_pkg::REG_CELL_WIDTH:  cw_q <= cfg_data_i;
        tsa_pkg::REG_CELL_HEIGHT: ch_q <= cfg_data_i;
        default:                  ;
      endcase
    end
  end

  assign cx = (cw_q == '0) ? tsa_pkg::CFG_W'(1) : cw_q;
  assign cy = (ch_q == '0) ? tsa_pkg::CFG_W'(1) : ch_q;

  // chain control
  assign en          = !v_q[TOT-1] || out_o.ready;
  assign in_i.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[TOT-2:0], in_i.valid};
  end

  // gradients scaled to a common denominator
  always_comb begin
    dx  = DW'(in_i.elev_left) - DW'(in_i.elev_right);
    dy  = DW'(in_i.elev_bottom) - DW'(in_i.elev_top);
    adx = ELEV_BITS'(dx[DW-1] ? -dx : dx);
    ady = ELEV_BITS'(dy[DW-1] ? -dy : dy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= AW'(adx) * AW'(cy);
      ay1_q  <= AW'(ady) * AW'(cx);
      c1_q   <= (CW2'(cx) * CW2'(cy)) << 1;
      dxn1_q <= dx[DW-1];
      dyn1_q <= dy[DW-1];
    end
  end

  // normalise, square, sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q.ax  <= ax1_q;
      sd2_q.ay  <= ay1_q;
      sd2_q.c   <= c1_q;
      sd2_q.len <= tsa_pkg::bitlen(64'((ax1_q > ay1_q) ? ax1_q : ay1_q));
      sd2_q.dxn <= dxn1_q;
      sd2_q.dyn <= dyn1_q;

      sd3_q <= sd2_q;
      if (sd2_q.len > 7'd31) begin
        a3_q <= 31'(64'(sd2_q.ax) >> (sd2_q.len - 7'd31));
        b3_q <= 31'(64'(sd2_q.ay) >> (sd2_q.len - 7'd31));
      end else begin
        a3_q <= 31'(64'(sd2_q.ax) << (7'd31 - sd2_q.len));
        b3_q <= 31'(64'(sd2_q.ay) << (7'd31 - sd2_q.len));
      end

      sd4_q <= sd3_q;
      aa4_q <= 62'(a3_q) * 62'(a3_q);
      bb4_q <= 62'(b3_q) * 62'(b3_q);

      sd5_q <= sd4_q;
      n5_q  <= 63'(aa4_q) + 63'(bb4_q);

      sd_q[0] <= sd5_q;
      for (int k = 1; k < NSQ; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  assign nw[0] = 64'(n5_q);
  assign rw[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    tsa_sqrt_cell #(.K(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (nw[k]),
      .res_i (rw[k]),
      .n_o   (nw[k+1]),
      .res_o (rw[k+1])
    );
  end

  // slope vector: run against rise, scaled back by the common shift
  always_comb begin
    s6 = sd_q[NSQ-1];
    h6 = 64'(rw[NSQ][31:0]);
    if (s6.len > 7'd31) begin
      sx6_d = 64'(s6.c);
      sy6_d = h6 << (s6.len - 7'd31);
    end else begin
      sx6_d = 64'(s6.c) << (7'd31 - s6.len);
      sy6_d = h6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx6_q      <= sx6_d;
      sy6_q      <= sy6_d;
      px6_q      <= 64'(s6.ay);
      py6_q      <= 64'(s6.ax);
      fl6_q.flat <= (s6.len == 7'd0);
      fl6_q.dxn  <= s6.dxn;
      fl6_q.dyn  <= s6.dyn;
      fl_q[0]    <= fl6_q;
      for (int j = 1; j < VLAT; j++) fl_q[j] <= fl_q[j-1];
    end
  end

  tsa_vec_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_slope (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (sx6_q),
    .y_i   (sy6_q),
    .ang_o (slope_ang)
  );

  tsa_vec_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_aspect (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (px6_q),
    .y_i   (py6_q),
    .ang_o (asp_base)
  );

  // quadrant fold
  always_comb begin
    case ({fl_q[VLAT-1].dxn, fl_q[VLAT-1].dyn})
      2'b00:   asp = BW'(asp_base);
      2'b01:   asp = (R1 << 1) - BW'(asp_base);
      2'b11:   asp = (R1 << 1) + BW'(asp_base);
      default: asp = (R1 << 2) - BW'(asp_base);
    endcase
    if (asp >= (R1 << 2)) asp = asp - (R1 << 2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      slope_q  <= fl_q[VLAT-1].flat ? '0 : SW'(slope_ang);
      aspect_q <= ASW'(asp);
    end
  end

  assign out_o.valid      = v_q[TOT-1];
  assign out_o.slope_deg  = slope_q;
  assign out_o.aspect_deg = aspect_q;

  property p_slope_range;
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid |-> (BW'(out_o.slope_deg) <= R1);
  endproperty
  a_slope_range: assert property (p_slope_range)
    else $error("slope beyond a right angle");

  property p_aspect_range;
    @(posedge clk_i) disable iff (!rst_ni)
      out_o.valid |-> (BW'(out_o.aspect_deg) < (R1 << 2));
  endproperty
  a_aspect_range: assert property (p_aspect_range)
    else $error("aspect not below a full turn");

  property p_stall_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      !en |=> $stable(v_q);
  endproperty
  a_stall_holds: assert property (p_stall_holds)
    else $error("chain moved while stalled");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for terrain_slope_aspect_core: a predictor computes the
// expected slope and aspect of each cell; a clocked driver and monitor run the
// handshakes under several idling phases and cell spacing settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int EW        = tsa_pkg::ELEV_BITS_DEF;
  localparam int FB        = tsa_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int SLOPE_W   = FB + 7;
  localparam int ASPECT_W  = FB + 9;
  localparam int LATENCY   = 124;
  localparam int STALL_MAX = 400000;

  typedef struct packed {
    logic signed [EW-1:0] top;
    logic signed [EW-1:0] bottom;
    logic signed [EW-1:0] left;
    logic signed [EW-1:0] right;
  } cell_t;

  typedef struct packed {
    logic [SLOPE_W-1:0]  slope;
    logic [ASPECT_W-1:0] aspect;
  } angles_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [tsa_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tsa_pkg::CFG_W-1:0]  cfg_data_i;

  tsa_in_if  #(.ELEV_BITS(EW))       in_if ();
  tsa_out_if #(.ANGLE_FRAC_BITS(FB)) out_if ();

  terrain_slope_aspect_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  cell_t   pending_cells[$];
  angles_t expected_angles[$];
  logic [63:0] atan_step[tsa_pkg::CORDIC_ITERS];
  logic [15:0] spacing_x, spacing_y;
  int  send_idle_pct, recv_stall_pct, hold_off;
  int  quiet_cycles;
  bit  failed;

  // atan(2^-i), 61 fractional bits, truncated series
  function automatic logic [63:0] series_atan(int i);
    logic [63:0] acc;
    int e;
    acc = 64'd0;
    if (i == 0) return tsa_pkg::PI_Q61 >> 2;
    for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
      e = 61 - i * (2 * k + 1);
      if (k % 2 == 1) acc = acc - (64'd1 << e) / 64'(2 * k + 1);
      else acc = acc + (64'd1 << e) / 64'(2 * k + 1);
    end
    return acc;
  endfunction

  function automatic int msb_len(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // rounded angle of (x, y) in the first quadrant, degrees
  function automatic logic [63:0] quadrant_angle(logic [63:0] x, logic [63:0] y);
    logic [63:0] right_ang, m, q, r;
    logic signed [63:0] xs, ys, zs, nx;
    int len, sh;
    right_ang = 64'd90 << FB;
    if (y == 0) return 0;
    if (x == 0) return right_ang;
    m = x > y ? x : y;
    len = msb_len(m);
    if (len > 58) begin
      sh = len - 58; x = x >> sh; y = y >> sh;
    end else begin
      sh = 58 - len; x = x << sh; y = y << sh;
    end
    if (y == 0) return 0;
    if (x == 0) return right_ang;
    xs = x; ys = y; zs = 0;
    for (int i = 0; i < tsa_pkg::CORDIC_ITERS; i++) begin
      if (ys > 0) begin
        nx = xs + (ys >>> i);
        ys = ys - (xs >>> i);
        zs = zs + $signed(atan_step[i]);
      end else begin
        nx = xs - (ys >>> i);
        ys = ys + (xs >>> i);
        zs = zs - $signed(atan_step[i]);
      end
      xs = nx;
    end
    if (zs < 0) zs = 0;
    if (zs > $signed(tsa_pkg::HALF_PI)) zs = tsa_pkg::HALF_PI;
    r = zs; q = 0;
    for (int i = 0; i < 40; i++) begin
      r = r << 1; q = q << 1;
      if (r >= tsa_pkg::PI_Q61) begin
        r = r - tsa_pkg::PI_Q61; q[0] = 1'b1;
      end
    end
    q = (((q * 180) << FB) + (64'd1 << 39)) >> 40;
    if (q > right_ang) q = right_ang;
    return q;
  endfunction

  function automatic angles_t slope_aspect(cell_t c);
    logic signed [63:0] dx, dy;
    logic [63:0] cx, cy, ax, ay, dbl, m, a, b, h, sx, sy, slope, base, asp, rt;
    int len, s;
    angles_t res;
    rt = 64'd90 << FB;
    cx = spacing_x == 0 ? 1 : spacing_x;
    cy = spacing_y == 0 ? 1 : spacing_y;
    dx = 64'(c.left) - 64'(c.right);
    dy = 64'(c.bottom) - 64'(c.top);
    ax = (dx < 0 ? -dx : dx) * cy;
    ay = (dy < 0 ? -dy : dy) * cx;
    dbl = 2 * cx * cy;
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      slope = 0;
    end else begin
      len = msb_len(m);
      if (len > 31) begin
        s = len - 31;
        a = ax >> s; b = ay >> s;
        h = floor_sqrt(a * a + b * b);
        sx = dbl; sy = h << s;
      end else begin
        s = 31 - len;
        a = ax << s; b = ay << s;
        h = floor_sqrt(a * a + b * b);
        sx = dbl << s; sy = h;
      end
      slope = quadrant_angle(sx, sy);
    end
    base = quadrant_angle(ay, ax);
    if (dx >= 0) asp = (dy >= 0) ? base : 2 * rt - base;
    else asp = (dy < 0) ? 2 * rt + base : 4 * rt - base;
    if (asp >= 4 * rt) asp = asp - 4 * rt;
    res.slope = slope[SLOPE_W-1:0];
    res.aspect = asp[ASPECT_W-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_angles.push_back(slope_aspect(pending_cells.pop_front()));
      end
      if ((!in_if.valid || in_if.ready) && pending_cells.size() != 0) begin
        if (in_if.valid && in_if.ready && pending_cells.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if ($urandom_range(99) >= send_idle_pct) begin
          in_if.valid       <= 1'b1;
          in_if.elev_top    <= pending_cells[0].top;
          in_if.elev_bottom <= pending_cells[0].bottom;
          in_if.elev_left   <= pending_cells[0].left;
          in_if.elev_right  <= pending_cells[0].right;
        end else begin
          in_if.valid <= 1'b0;
        end
      end else if (!in_if.valid || in_if.ready) begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t exp_a;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected item slope %0d aspect %0d", out_if.slope_deg,
                 out_if.aspect_deg);
          failed = 1'b1;
        end else begin
          exp_a = expected_angles.pop_front();
          if (out_if.slope_deg !== exp_a.slope) begin
            $error("slope_deg exp %0d got %0d", exp_a.slope, out_if.slope_deg);
            failed = 1'b1;
          end
          if (out_if.aspect_deg !== exp_a.aspect) begin
            $error("aspect_deg exp %0d got %0d", exp_a.aspect, out_if.aspect_deg);
            failed = 1'b1;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (hold_off > 0) begin
        hold_off     <= hold_off - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles > STALL_MAX) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic cell_t rand_cell();
    cell_t c;
    int mag;
    c.top = EW'($urandom); c.bottom = EW'($urandom);
    c.left = EW'($urandom); c.right = EW'($urandom);
    mag = $urandom_range(3);
    if (mag == 0) begin
      // gentle terrain: small differences around a random base
      c.bottom = c.top + $signed(EW'($urandom_range(64) - 32));
      c.right  = c.left + $signed(EW'($urandom_range(64) - 32));
    end else if (mag == 1) begin
      c.bottom = c.top + $signed(EW'($urandom_range(4000) - 2000));
      c.right  = c.left + $signed(EW'($urandom_range(4000) - 2000));
    end
    if ($urandom_range(15) == 0) c.right = c.left;
    if ($urandom_range(15) == 0) c.bottom = c.top;
    return c;
  endfunction

  task automatic write_reg(logic [tsa_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tsa_pkg::REG_CELL_WIDTH) spacing_x = val;
    else spacing_y = val;
  endtask

  task automatic drain();
    while (pending_cells.size() != 0 || in_if.valid || expected_angles.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic directed_cells();
    logic signed [EW-1:0] mx, mn;
    cell_t c;
    mx = {1'b0, {(EW-1){1'b1}}};
    mn = {1'b1, {(EW-1){1'b0}}};
    c = '{0, 0, 0, 0};           pending_cells.push_back(c);
    c = '{5, 5, 9, 9};           pending_cells.push_back(c);
    c = '{0, 10, 0, 0};          pending_cells.push_back(c);
    c = '{10, 0, 0, 0};          pending_cells.push_back(c);
    c = '{0, 0, 10, 0};          pending_cells.push_back(c);
    c = '{0, 0, 0, 10};          pending_cells.push_back(c);
    c = '{0, 1, 1, 0};           pending_cells.push_back(c);
    c = '{1, 0, 1, 0};           pending_cells.push_back(c);
    c = '{1, 0, 0, 1};           pending_cells.push_back(c);
    c = '{0, 1, 0, 1};           pending_cells.push_back(c);
    c = '{mn, mx, mx, mn};       pending_cells.push_back(c);
    c = '{mx, mn, mn, mx};       pending_cells.push_back(c);
    c = '{mx, mn, mx, mn};       pending_cells.push_back(c);
    c = '{mn, mx, mn, mx};       pending_cells.push_back(c);
    c = '{0, 1, 0, 1000000 - 1048576}; pending_cells.push_back(c);
    c = '{0, -1, 1, 0};          pending_cells.push_back(c);
    c = '{mx, mx, mx, mx};       pending_cells.push_back(c);
    c = '{-1, -1, -1, 0};        pending_cells.push_back(c);
  endtask

  initial begin
    logic [15:0] wx[6], wy[6];
    int idle_s[4], idle_r[4];
    failed = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    spacing_x = 16'd1; spacing_y = 16'd1;
    for (int i = 0; i < tsa_pkg::CORDIC_ITERS; i++) atan_step[i] = series_atan(i);
    in_if.valid = 1'b0;
    in_if.elev_top = '0; in_if.elev_bottom = '0;
    in_if.elev_left = '0; in_if.elev_right = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_cells();
    drain();

    wx = '{16'd0, 16'd65535, 16'd1, 16'd30, 16'd65535, 16'd0};
    wy = '{16'd0, 16'd65535, 16'd65535, 16'd7, 16'd1, 16'd0};
    idle_s = '{0, 74, 0, 36};
    idle_r = '{0, 0, 74, 36};
    for (int p = 0; p < 6; p++) begin
      write_reg(tsa_pkg::REG_CELL_WIDTH, p == 5 ? 16'($urandom) : wx[p]);
      write_reg(tsa_pkg::REG_CELL_HEIGHT, p == 5 ? 16'($urandom) : wy[p]);
      if (p == 1) directed_cells();
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = idle_s[ph];
        recv_stall_pct = idle_r[ph];
        // long hold-off with more items than the chain holds
        if (p == 0 && ph == 0) hold_off = 300;
        for (int n = 0; n < ((p == 0 && ph == 0) ? 200 : 40); n++)
          pending_cells.push_back(rand_cell());
        while (pending_cells.size() != 0) @(posedge clk_i);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (!failed && expected_angles.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tsa_pkg.sv
hdl/tsa_in_if.sv
hdl/tsa_out_if.sv
hdl/tsa_sqrt_cell.sv
hdl/tsa_cordic_cell.sv
hdl/tsa_div_cell.sv
hdl/tsa_vec_angle.sv
hdl/terrain_slope_aspect_core.sv
tb/tb.sv
